// ----- hdl/gasa_pkg.sv -----
// shared types, codes and constants of the glyph atlas shelf allocator
`timescale 1ns / 1ps
`default_nettype none

package gasa_pkg;

  // gap in pixels kept around every glyph
  localparam int GAP = 2;

  // fixed widths of the word fields
  localparam int ID_W     = 32;
  localparam int SIZE_W   = 12;
  localparam int POS_W    = 11;
  localparam int METRIC_W = 16;
  localparam int STATUS_W = 3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_PLACED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MISSING = 3'd3;
  localparam logic [STATUS_W-1:0] ST_REJECT  = 3'd4;

  // one cache entry as held in the table memory
  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [POS_W-1:0]    x;
    logic [POS_W-1:0]    y;
    logic [SIZE_W-1:0]   w;
    logic [SIZE_W-1:0]   h;
    logic [METRIC_W-1:0] left;
    logic [METRIC_W-1:0] top;
    logic [METRIC_W-1:0] adv;
  } entry_t;

  // what the output register is loaded with
  typedef enum logic [2:0] {
    OUT_NONE,
    OUT_HIT,
    OUT_MISS,
    OUT_REJECT,
    OUT_PLACE
  } out_sel_t;

  // controller to datapath
  typedef struct packed {
    logic     load;
    logic     scan;
    logic     wrap;
    logic     place;
    out_sel_t out_sel;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic lookup;
    logic zero_size;
    logic oversize;
    logic hit;
    logic scan_end;
    logic out_free;
  } sts_t;

endpackage : gasa_pkg

`default_nettype wire

// ----- hdl/gasa_dp.sv -----
// datapath: item registers, entry table, packing cursors and output register
`timescale 1ns / 1ps
`default_nettype none

module gasa_dp
  import gasa_pkg::*;
#(
  parameter int ATLAS_DIM   = 2048,
  parameter int MAX_ENTRIES = 256
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire cmd_t                       cmd,
  output sts_t                            sts,
  input  wire logic                       in_func,
  input  wire logic [ID_W-1:0]            in_glyph_id,
  input  wire logic [SIZE_W-1:0]          in_width,
  input  wire logic [SIZE_W-1:0]          in_height,
  input  wire logic [METRIC_W-1:0]        in_bearing_left,
  input  wire logic [METRIC_W-1:0]        in_bearing_top,
  input  wire logic [METRIC_W-1:0]        in_advance_px,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [STATUS_W-1:0]             out_status,
  output logic                            out_evicted,
  output entry_t                          res_entry
);

  localparam int AW    = $clog2(MAX_ENTRIES);
  localparam int CNT_W = AW + 1;
  // cursor width: holds any value below four atlas widths and any 12-bit size plus gap
  localparam int CW    = ($clog2(ATLAS_DIM) + 2 > SIZE_W + 1) ?
                         ($clog2(ATLAS_DIM) + 2) : (SIZE_W + 1);

  localparam logic [CW-1:0]    DIM_C   = CW'(ATLAS_DIM);
  localparam logic [CW-1:0]    GAP_C   = CW'(GAP);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

  entry_t mem [MAX_ENTRIES];
  entry_t rd_q_r;

  // latched item
  logic                func_r;
  logic [ID_W-1:0]     id_r;
  logic [SIZE_W-1:0]   w_r;
  logic [SIZE_W-1:0]   h_r;
  logic [METRIC_W-1:0] left_r;
  logic [METRIC_W-1:0] top_r;
  logic [METRIC_W-1:0] adv_r;

  // control state
  logic [CNT_W-1:0] total_r, total_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             pend_r, pend_nxt;
  logic [CW-1:0]    cx_r, cx_nxt;
  logic [CW-1:0]    cy_r, cy_nxt;
  logic [CW-1:0]    rh_r, rh_nxt;
  logic             out_valid_r, out_valid_nxt;

  // output payload
  logic [STATUS_W-1:0] status_r;
  logic                evicted_r;
  entry_t              res_entry_r;

  logic [CW-1:0]    wx, hx;
  logic             scan_more;
  logic             wrap_need;
  logic             evict;
  logic [CW-1:0]    px, py, rh_base;
  logic [CNT_W-1:0] slot;
  entry_t           new_entry;

  always_comb begin
    wx        = CW'(w_r);
    hx        = CW'(h_r);
    scan_more = idx_r < total_r;
    wrap_need = (cx_r + wx + GAP_C) > DIM_C;
    evict     = ((cy_r + hx + GAP_C) > DIM_C) || (total_r >= MAX_CNT);
    px        = evict ? GAP_C : cx_r;
    py        = evict ? GAP_C : cy_r;
    rh_base   = evict ? '0 : rh_r;
    slot      = evict ? '0 : total_r;

    new_entry.id   = id_r;
    new_entry.x    = px[POS_W-1:0];
    new_entry.y    = py[POS_W-1:0];
    new_entry.w    = w_r;
    new_entry.h    = h_r;
    new_entry.left = left_r;
    new_entry.top  = top_r;
    new_entry.adv  = adv_r;

    sts.lookup    = func_r;
    sts.zero_size = !func_r && ((w_r == '0) || (h_r == '0));
    sts.oversize  = ((wx + GAP_C) > DIM_C) || ((hx + GAP_C) > DIM_C);
    sts.hit       = pend_r && (rd_q_r.id == id_r);
    sts.scan_end  = !pend_r && !scan_more;
    sts.out_free  = !out_valid_r || !out_stall;
  end

  always_comb begin
    total_nxt     = total_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    rh_nxt        = rh_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_sel != OUT_NONE) begin
      out_valid_nxt = 1'b1;
    end

    if (cmd.load) begin
      idx_nxt  = '0;
      pend_nxt = 1'b0;
    end
    if (cmd.scan) begin
      pend_nxt = scan_more;
      if (scan_more) begin
        idx_nxt = idx_r + 1'b1;
      end
    end
    // start a new shelf below the tallest glyph of this one
    if (cmd.wrap && wrap_need) begin
      cx_nxt = GAP_C;
      cy_nxt = cy_r + rh_r + GAP_C;
      rh_nxt = '0;
    end
    if (cmd.place) begin
      total_nxt = slot + 1'b1;
      cx_nxt    = px + wx + GAP_C;
      cy_nxt    = py;
      rh_nxt    = (hx > rh_base) ? hx : rh_base;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      cx_r        <= GAP_C;
      cy_r        <= GAP_C;
      rh_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      total_r     <= total_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      cx_r        <= cx_nxt;
      cy_r        <= cy_nxt;
      rh_r        <= rh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      id_r   <= in_glyph_id;
      w_r    <= in_width;
      h_r    <= in_height;
      left_r <= in_bearing_left;
      top_r  <= in_bearing_top;
      adv_r  <= in_advance_px;
    end
    case (cmd.out_sel)
      OUT_HIT: begin
        status_r    <= func_r ? ST_FOUND : ST_PRESENT;
        evicted_r   <= 1'b0;
        res_entry_r <= rd_q_r;
      end
      OUT_MISS: begin
        status_r    <= ST_MISSING;
        evicted_r   <= 1'b0;
        res_entry_r <= '0;
      end
      OUT_REJECT: begin
        status_r    <= ST_REJECT;
        evicted_r   <= 1'b0;
        res_entry_r <= '0;
      end
      OUT_PLACE: begin
        status_r    <= ST_PLACED;
        evicted_r   <= evict;
        res_entry_r <= new_entry;
      end
      default: begin
      end
    endcase
  end

  // entry table, one read and one write port
  always_ff @(posedge clk) begin
    if (cmd.scan && scan_more) begin
      rd_q_r <= mem[idx_r[AW-1:0]];
    end
    if (cmd.place) begin
      mem[slot[AW-1:0]] <= new_entry;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = status_r;
  assign out_evicted = evicted_r;
  assign res_entry   = res_entry_r;

  a_total_bound : assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= MAX_CNT)
    else $error("entry count beyond table depth");

  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_sel != OUT_NONE) |-> (!out_valid_r || !out_stall))
    else $error("result loaded over an unconsumed word");

  a_pend_after_read : assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan && scan_more) |=> (pend_r && idx_r != '0))
    else $error("table read issued without pending data");

  // a glyph as wide as the atlas allows leaves the cursor one gap past the edge
  a_cursor_in_atlas : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.place |=> (cx_r <= DIM_C + GAP_C))
    else $error("cursor beyond atlas after placement");

endmodule : gasa_dp

`default_nettype wire

// ----- hdl/gasa_ctrl.sv -----
// controller state machine sequencing search, shelf wrap and placement
`timescale 1ns / 1ps
`default_nettype none

module gasa_ctrl
  import gasa_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_WRAP,
    S_PLACE
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r, in_stall_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd.load    = 1'b0;
    cmd.scan    = 1'b0;
    cmd.wrap    = 1'b0;
    cmd.place   = 1'b0;
    cmd.out_sel = OUT_NONE;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall_r) begin
          cmd.load  = 1'b1;
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (sts.zero_size) begin
          if (sts.out_free) begin
            cmd.out_sel = OUT_REJECT;
            state_nxt   = S_IDLE;
          end
        end else if (sts.hit) begin
          if (sts.out_free) begin
            cmd.out_sel = OUT_HIT;
            state_nxt   = S_IDLE;
          end
        end else if (sts.scan_end) begin
          if (sts.lookup) begin
            if (sts.out_free) begin
              cmd.out_sel = OUT_MISS;
              state_nxt   = S_IDLE;
            end
          end else if (sts.oversize) begin
            if (sts.out_free) begin
              cmd.out_sel = OUT_REJECT;
              state_nxt   = S_IDLE;
            end
          end else begin
            state_nxt = S_WRAP;
          end
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_WRAP: begin
        cmd.wrap  = 1'b1;
        state_nxt = S_PLACE;
      end
      S_PLACE: begin
        if (sts.out_free) begin
          cmd.place   = 1'b1;
          cmd.out_sel = OUT_PLACE;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    in_stall_nxt = (state_nxt != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_stall_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= in_stall_nxt;
    end
  end

  assign in_stall = in_stall_r;

  a_place_after_wrap : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PLACE) |-> ($past(state_r) == S_WRAP || $past(state_r) == S_PLACE))
    else $error("placement entered without shelf check");

  a_stall_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load) |=> in_stall_r)
    else $error("input open while an item is in work");

  a_stall_tracks_state : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall_r == (state_r != S_IDLE))
    else $error("input stall out of step with the state");

endmodule : gasa_ctrl

`default_nettype wire

// ----- hdl/glyph_atlas_shelf_allocator_core.sv -----
// top level of the glyph atlas shelf allocator: controller plus datapath
// usage
//   input channel in_*: one word per upload (in_func = 0) or lookup (in_func = 1),
//   taken at an edge with in_valid high and in_stall low
//   result channel out_*: exactly one word per input word, in order, held while
//   out_stall is high
// timing
//   an item scans the id table one entry per cycle from the registered read port
//   of the table memory; a new glyph then takes the shelf check and placement;
//   the next item can be taken in the cycle after its result word is loaded,
//   and one item is in work at a time
// stalling
//   the result sits in an output register; the next item is taken while it waits,
//   and only the loading of a new result holds off until that word has gone
// reset
//   synchronous, active low; empties the cache and puts the packing cursor at
//   (2,2) with a zero shelf height; table contents need no clearing
`timescale 1ns / 1ps
`default_nettype none

module glyph_atlas_shelf_allocator_core
  import gasa_pkg::*;
#(
  parameter int ATLAS_DIM   = 2048,
  parameter int MAX_ENTRIES = 256
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // input channel
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_func,
  input  wire logic [ID_W-1:0]             in_glyph_id,
  input  wire logic [SIZE_W-1:0]           in_width,
  input  wire logic [SIZE_W-1:0]           in_height,
  input  wire logic signed [METRIC_W-1:0]  in_bearing_left,
  input  wire logic signed [METRIC_W-1:0]  in_bearing_top,
  input  wire logic signed [METRIC_W-1:0]  in_advance_px,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [STATUS_W-1:0]              out_status,
  output logic                             out_evicted,
  output logic [POS_W-1:0]                 out_pos_x,
  output logic [POS_W-1:0]                 out_pos_y,
  output logic [SIZE_W-1:0]                out_width,
  output logic [SIZE_W-1:0]                out_height,
  output logic signed [METRIC_W-1:0]       out_bearing_left,
  output logic signed [METRIC_W-1:0]       out_bearing_top,
  output logic signed [METRIC_W-1:0]       out_advance
);

  cmd_t   cmd;
  sts_t   sts;
  entry_t res_entry;

  // sequencing of scan, shelf wrap and placement
  gasa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // table memory, cursors and result register
  gasa_dp #(
    .ATLAS_DIM   (ATLAS_DIM),
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_func         (in_func),
    .in_glyph_id     (in_glyph_id),
    .in_width        (in_width),
    .in_height       (in_height),
    .in_bearing_left (in_bearing_left),
    .in_bearing_top  (in_bearing_top),
    .in_advance_px   (in_advance_px),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_evicted     (out_evicted),
    .res_entry       (res_entry)
  );

  // the stored entry fans out to the result ports
  assign out_pos_x        = res_entry.x;
  assign out_pos_y        = res_entry.y;
  assign out_width        = res_entry.w;
  assign out_height       = res_entry.h;
  assign out_bearing_left = $signed(res_entry.left);
  assign out_bearing_top  = $signed(res_entry.top);
  assign out_advance      = $signed(res_entry.adv);

endmodule : glyph_atlas_shelf_allocator_core

`default_nettype wire
